// ===== design/assert_macros.svh =====
// Assertion helpers shared by the framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, held off while in reset.
`define PBF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same-cycle implication.
`define PBF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PBF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pbf_pkg.sv =====
package pbf_pkg;

	localparam int FRAME_MAX = 9;
	localparam int IDX_W = $clog2(FRAME_MAX);
	localparam int LEN_W = 18;

	localparam logic [7:0] PUBLISH_TYPE = 8'd12;
	localparam logic [7:0] WIDE_MARK = 8'h01;
	localparam logic [LEN_W-1:0] BODY_BASE = 18'd6;
	localparam logic [LEN_W-1:0] WIDE_THRESH = 18'd255;
	localparam logic [LEN_W-1:0] WIDE_EXTRA = 18'd3;
	localparam logic [LEN_W-1:0] NARROW_EXTRA = 18'd1;
	localparam logic [15:0] LIMIT_RESET = 16'd512;
	localparam logic [IDX_W-1:0] LAST_WIDE = IDX_W'(FRAME_MAX - 1);
	localparam logic [IDX_W-1:0] LAST_NARROW = IDX_W'(FRAME_MAX - 3);

	localparam logic [1:0] KIND_NORMAL = 2'd0;
	localparam logic [1:0] QOS_NOCONN = 2'd3;

	typedef enum logic {
		REQ_START = 1'b0,
		REQ_BODY  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_STRAY = 2'd2
	} status_t;

	typedef struct packed {
		logic        req_type;
		logic        dup_flag;
		logic [1:0]  qos_level;
		logic        retain_flag;
		logic [1:0]  topic_kind;
		logic [15:0] topic_word;
		logic [15:0] message_id;
		logic [15:0] name_length;
		logic [15:0] payload_length;
		logic [7:0]  data_byte;
	} req_item_t;

	// One request's worth of output: bytes[0] goes out first.
	typedef struct packed {
		logic [FRAME_MAX-1:0][7:0] bytes;
		logic [IDX_W-1:0]          last_idx;
		logic                      byte_valid;
		status_t                   status;
		logic                      packet_end;
	} frame_t;

endpackage

// ===== design/pbf_req_if.sv =====
interface pbf_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic        dup_flag;
	logic [1:0]  qos_level;
	logic        retain_flag;
	logic [1:0]  topic_kind;
	logic [15:0] topic_word;
	logic [15:0] message_id;
	logic [15:0] name_length;
	logic [15:0] payload_length;
	logic [7:0]  data_byte;

	modport source (
		output valid, req_type, dup_flag, qos_level, retain_flag, topic_kind,
		       topic_word, message_id, name_length, payload_length, data_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, dup_flag, qos_level, retain_flag, topic_kind,
		       topic_word, message_id, name_length, payload_length, data_byte,
		output ready
	);
endinterface

// ===== design/pbf_res_if.sv =====
interface pbf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [1:0] status;
	logic       run_last;
	logic       packet_end;

	modport source (
		output valid, out_byte, byte_valid, status, run_last, packet_end,
		input  ready
	);
	modport sink (
		input  valid, out_byte, byte_valid, status, run_last, packet_end,
		output ready
	);
endinterface

// ===== design/pbf_cfg_if.sv =====
interface pbf_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/pbf_frame_build.sv =====
`include "assert_macros.svh"

module pbf_frame_build import pbf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t item,
	input  logic      fire,
	input  logic      cfg_we,
	input  logic [15:0] cfg_data,
	output frame_t    frame
);

	logic        open_q;
	logic [15:0] name_left_q;
	logic [15:0] pay_left_q;
	logic [15:0] limit_q;

	logic             long_name;
	logic [LEN_W-1:0] body;
	logic [LEN_W-1:0] total;
	logic             wide;
	logic             too_short;
	logic             empty;
	logic [15:0]      name_init;
	logic [15:0]      topic_sel;
	logic [7:0]       flags;
	logic [15:0]      name_dec;
	logic [15:0]      pay_dec;
	logic             done;
	logic [5:0][7:0]  tail;

	always_comb begin
		long_name = (item.topic_kind == KIND_NORMAL) && (item.qos_level == QOS_NOCONN);
		name_init = long_name ? item.name_length : 16'd0;
		body = BODY_BASE + {2'b00, item.payload_length} + {2'b00, name_init};
		wide = (body >= WIDE_THRESH);
		total = body + (wide ? WIDE_EXTRA : NARROW_EXTRA);
		too_short = (total > {2'b00, limit_q});
		empty = (name_init == 16'd0) && (item.payload_length == 16'd0);
		topic_sel = long_name ? item.name_length : item.topic_word;
		flags = {item.dup_flag, item.qos_level, item.retain_flag, 2'b00, item.topic_kind};

		// name bytes drain first, then payload
		name_dec = name_left_q;
		pay_dec = pay_left_q;
		if (name_left_q != 16'd0) begin
			name_dec = name_left_q - 16'd1;
		end else if (pay_left_q != 16'd0) begin
			pay_dec = pay_left_q - 16'd1;
		end
		done = (name_dec == 16'd0) && (pay_dec == 16'd0);

		tail = {item.message_id[7:0], item.message_id[15:8], topic_sel[7:0],
			topic_sel[15:8], flags, PUBLISH_TYPE};
	end

	always_comb begin
		frame = '0;
		frame.status = ST_OK;
		if (item.req_type == REQ_BODY) begin
			if (!open_q) begin
				frame.status = ST_STRAY;
			end else begin
				frame.bytes[0] = item.data_byte;
				frame.byte_valid = 1'b1;
				frame.packet_end = done;
			end
		end else if (too_short) begin
			frame.status = ST_SHORT;
		end else begin
			frame.byte_valid = 1'b1;
			frame.packet_end = empty;
			if (wide) begin
				frame.bytes = {tail, total[7:0], total[15:8], WIDE_MARK};
				frame.last_idx = LAST_WIDE;
			end else begin
				frame.bytes = {16'h0000, tail, total[7:0]};
				frame.last_idx = LAST_NARROW;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			name_left_q <= '0;
			pay_left_q <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (fire) begin
				if (item.req_type == REQ_BODY) begin
					if (open_q) begin
						name_left_q <= name_dec;
						pay_left_q <= pay_dec;
						open_q <= !done;
					end
				end else if (too_short) begin
					open_q <= 1'b0;
					name_left_q <= '0;
					pay_left_q <= '0;
				end else begin
					open_q <= !empty;
					name_left_q <= name_init;
					pay_left_q <= item.payload_length;
				end
			end
		end
	end

	`PBF_ASSERT(open_tracks_counts, clk, arst_n, open_q == ((name_left_q != 16'd0) || (pay_left_q != 16'd0)), "open flag disagrees with byte counts")

endmodule

// ===== design/pbf_frame_emit.sv =====
`include "assert_macros.svh"

module pbf_frame_emit import pbf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  frame_t frame,
	pbf_res_if.source res
);

	logic   main_v_q;
	logic   skid_v_q;
	frame_t main_q;
	frame_t skid_q;

	logic fire;
	logic take;
	logic fin;
	logic load_new;

	always_comb begin
		in_ready = !skid_v_q;
		fire = in_valid && in_ready;
		take = main_v_q && res.ready;
		fin = take && (main_q.last_idx == '0);
		load_new = fire && (!main_v_q || fin);
	end

	assign res.valid = main_v_q;
	assign res.out_byte = main_q.bytes[0];
	assign res.byte_valid = main_q.byte_valid;
	assign res.status = main_q.status;
	assign res.run_last = (main_q.last_idx == '0);
	assign res.packet_end = main_q.packet_end && (main_q.last_idx == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (load_new) begin
				main_v_q <= 1'b1;
			end else if (fin) begin
				main_v_q <= skid_v_q;
			end
			if (fire && !load_new) begin
				skid_v_q <= 1'b1;
			end else if (fin) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_new) begin
			main_q <= frame;
		end else if (fin) begin
			main_q <= skid_q;
		end else if (take) begin
			// next header byte moves to the front
			main_q.bytes <= main_q.bytes >> 8;
			main_q.last_idx <= main_q.last_idx - IDX_W'(1);
		end
		if (fire && !load_new) begin
			skid_q <= frame;
		end
	end

	`PBF_ASSERT_IMP(skid_needs_main, clk, arst_n, skid_v_q, main_v_q, "skid holds a request while output is empty")
	`PBF_ASSERT_NXT(skid_drains, clk, arst_n, fin && skid_v_q, main_v_q && !skid_v_q, "skid not moved to output")
	`PBF_ASSERT_IMP(idx_in_range, clk, arst_n, main_v_q, main_q.last_idx <= LAST_WIDE, "byte index out of range")

endmodule

// ===== design/pubsub_publish_framer.sv =====
// Publish packet framer.
// A request's frame is registered into the output register, or into the skid while the output is busy.
// Throughput: one request per cycle while the skid is empty; a framed start request
// sends 7 or 9 header bytes (one per cycle on res.ready), any other (refused too) one byte.
// A two-entry output buffer (output register plus skid) sets the request acceptance.
// Reset (arst_n low, asynchronous): no open packet, counts zero, buffer limit 512.
module pubsub_publish_framer import pbf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pbf_req_if.sink   req,
	pbf_res_if.source res,
	pbf_cfg_if.sink   cfg
);

	req_item_t item;
	frame_t    frame;
	logic      in_ready;
	logic      fire;

	always_comb begin
		item.req_type = req.req_type;
		item.dup_flag = req.dup_flag;
		item.qos_level = req.qos_level;
		item.retain_flag = req.retain_flag;
		item.topic_kind = req.topic_kind;
		item.topic_word = req.topic_word;
		item.message_id = req.message_id;
		item.name_length = req.name_length;
		item.payload_length = req.payload_length;
		item.data_byte = req.data_byte;
	end

	assign req.ready = in_ready;
	assign fire = req.valid && in_ready;
	assign cfg.ready = 1'b1;

	pbf_frame_build u_build (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.fire     (fire),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.frame    (frame)
	);

	pbf_frame_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.frame    (frame),
		.res      (res)
	);

endmodule

// ===== test/testbench.sv =====
module testbench import pbf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int N_DIRECTED = 21;

	typedef struct packed {
		logic [7:0] data;
		logic       vld;
		status_t    status;
		logic       last;
		logic       pend;
	} frame_byte_t;

	typedef struct {
		req_item_t item;
		bit        typed;
		status_t   st;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	pbf_req_if req_ch ();
	pbf_res_if res_ch ();
	pbf_cfg_if cfg_ch ();

	pubsub_publish_framer uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// framer shadow state
	logic [15:0] limit_shadow = LIMIT_RESET;
	logic        open_shadow = 1'b0;
	logic [15:0] name_left = '0;
	logic [15:0] pay_left = '0;

	frame_byte_t pending_bytes[$];
	stim_row_t   dir_rows[N_DIRECTED];
	int          err_count = 0;
	int          cycle_count = 0;
	bit          idling = 1'b1;

	function automatic void frame_publish(input req_item_t it, ref frame_byte_t outs[$]);
		int          body;
		int          total;
		logic        long_name;
		logic        empty;
		logic [15:0] tw;
		logic [7:0]  hdr[$];
		if (it.req_type == REQ_BODY) begin
			if (!open_shadow) begin
				outs.push_back('{8'h00, 1'b0, ST_STRAY, 1'b1, 1'b0});
				return;
			end
			if (name_left != 0)
				name_left--;
			else if (pay_left != 0)
				pay_left--;
			empty = (name_left == 0) && (pay_left == 0);
			if (empty)
				open_shadow = 1'b0;
			outs.push_back('{it.data_byte, 1'b1, ST_OK, 1'b1, empty});
			return;
		end
		long_name = (it.topic_kind == KIND_NORMAL) && (it.qos_level == QOS_NOCONN);
		body = int'(BODY_BASE) + int'(it.payload_length)
			+ (long_name ? int'(it.name_length) : 0);
		total = (body >= int'(WIDE_THRESH)) ? body + int'(WIDE_EXTRA)
			: body + int'(NARROW_EXTRA);
		open_shadow = 1'b0;
		name_left = '0;
		pay_left = '0;
		if (total > int'(limit_shadow)) begin
			outs.push_back('{8'h00, 1'b0, ST_SHORT, 1'b1, 1'b0});
			return;
		end
		if (body >= int'(WIDE_THRESH)) begin
			hdr.push_back(WIDE_MARK);
			hdr.push_back(total[15:8]);
		end
		hdr.push_back(total[7:0]);
		hdr.push_back(PUBLISH_TYPE);
		hdr.push_back({it.dup_flag, it.qos_level, it.retain_flag, 2'b00, it.topic_kind});
		tw = long_name ? it.name_length : it.topic_word;
		hdr.push_back(tw[15:8]);
		hdr.push_back(tw[7:0]);
		hdr.push_back(it.message_id[15:8]);
		hdr.push_back(it.message_id[7:0]);
		name_left = long_name ? it.name_length : 16'd0;
		pay_left = it.payload_length;
		empty = (name_left == 0) && (pay_left == 0);
		open_shadow = !empty;
		foreach (hdr[i])
			outs.push_back('{hdr[i], 1'b1, ST_OK, i == hdr.size() - 1,
				(i == hdr.size() - 1) && empty});
	endfunction

	function automatic stim_row_t mk_start(input logic d, input logic [1:0] q, input logic r,
			input logic [1:0] k, input logic [15:0] t, input logic [15:0] m,
			input logic [15:0] nl, input logic [15:0] pl);
		stim_row_t row;
		row.item = '{REQ_START, d, q, r, k, t, m, nl, pl, 8'h00};
		row.typed = 1'b0;
		row.st = ST_OK;
		return row;
	endfunction

	function automatic stim_row_t mk_body(input logic [7:0] b);
		stim_row_t row;
		row.item = '{REQ_BODY, 1'b0, 2'd0, 1'b0, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0, b};
		row.typed = 1'b0;
		row.st = ST_OK;
		return row;
	endfunction

	// single error result, typed in directly
	function automatic stim_row_t typed_err(input stim_row_t row, input status_t st);
		row.typed = 1'b1;
		row.st = st;
		return row;
	endfunction

	function automatic req_item_t rand_header(input bit wild);
		req_item_t it;
		it.req_type = REQ_START;
		it.dup_flag = 1'($urandom_range(0, 1));
		it.qos_level = 2'($urandom_range(0, 3));
		it.retain_flag = 1'($urandom_range(0, 1));
		it.topic_kind = 2'($urandom_range(0, 3));
		it.topic_word = 16'($urandom);
		it.message_id = 16'($urandom);
		it.data_byte = 8'($urandom);
		if (wild) begin
			it.name_length = 16'($urandom);
			it.payload_length = 16'($urandom);
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				it.topic_kind = KIND_NORMAL;
				it.qos_level = QOS_NOCONN;
			end
			it.name_length = 16'($urandom_range(0, 6));
			// now and then sit around the one/three byte length boundary
			it.payload_length = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(240, 260))
				: 16'($urandom_range(0, 12));
		end
		return it;
	endfunction

	function automatic req_item_t rand_body();
		req_item_t it;
		it = rand_header(1'b1);
		it.req_type = REQ_BODY;
		return it;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endfunction

	task automatic send_req(input req_item_t it, input bit typed, input status_t st);
		frame_byte_t outs[$];
		if (idling && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.req_type;
		req_ch.dup_flag <= it.dup_flag;
		req_ch.qos_level <= it.qos_level;
		req_ch.retain_flag <= it.retain_flag;
		req_ch.topic_kind <= it.topic_kind;
		req_ch.topic_word <= it.topic_word;
		req_ch.message_id <= it.message_id;
		req_ch.name_length <= it.name_length;
		req_ch.payload_length <= it.payload_length;
		req_ch.data_byte <= it.data_byte;
		do @(posedge clk); while (!req_ch.ready);
		frame_publish(it, outs);
		if (typed)
			pending_bytes.push_back('{8'h00, 1'b0, st, 1'b1, 1'b0});
		else
			pending_bytes = {pending_bytes, outs};
	endtask

	task automatic drain();
		if (pending_bytes.size() != 0) begin
			req_ch.valid <= 1'b0;
			while (pending_bytes.size() != 0) @(posedge clk);
		end
	endtask

	task automatic set_limit(input logic [15:0] v);
		req_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		limit_shadow = v;
	endtask

	task automatic run_phase(input int n_items);
		int        sent;
		int        pick;
		int        nbody;
		req_item_t it;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				it = rand_header(1'b0);
				nbody = int'(it.payload_length);
				if (it.topic_kind == KIND_NORMAL && it.qos_level == QOS_NOCONN)
					nbody += int'(it.name_length);
				if (nbody > 24 || $urandom_range(0, 4) == 0)
					nbody = $urandom_range(0, (nbody > 4) ? 4 : nbody);  // abandoned
				else if ($urandom_range(0, 5) == 0)
					nbody += $urandom_range(1, 2);  // overrun into strays
				send_req(it, 1'b0, ST_OK);
				sent++;
				repeat (nbody) begin
					send_req(rand_body(), 1'b0, ST_OK);
					sent++;
				end
			end else if (pick < 17) begin
				send_req(rand_header(1'b1), 1'b0, ST_OK);
				sent++;
			end else if (pick < 19) begin
				send_req(rand_body(), 1'b0, ST_OK);
				sent++;
			end else if (idling) begin
				drain();
			end
		end
	endtask

	// result side: random back-pressure and checking
	initial begin
		int          stall;
		frame_byte_t want;
		stall = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				if (pending_bytes.size() == 0) begin
					$error("result with nothing expected: byte 0x%0h status %0d",
						res_ch.out_byte, res_ch.status);
					err_count++;
				end else begin
					want = pending_bytes.pop_front();
					check_field("out_byte", want.data, res_ch.out_byte);
					check_field("byte_valid", 8'(want.vld), 8'(res_ch.byte_valid));
					check_field("status", 8'(want.status), 8'(res_ch.status));
					check_field("run_last", 8'(want.last), 8'(res_ch.run_last));
					check_field("packet_end", 8'(want.pend), 8'(res_ch.packet_end));
				end
			end
			if (idling && stall > 0) begin
				stall--;
				res_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 6) == 0) begin
				stall = $urandom_range(1, 11) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_START;
		req_ch.dup_flag <= 1'b0;
		req_ch.qos_level <= '0;
		req_ch.retain_flag <= 1'b0;
		req_ch.topic_kind <= '0;
		req_ch.topic_word <= '0;
		req_ch.message_id <= '0;
		req_ch.name_length <= '0;
		req_ch.payload_length <= '0;
		req_ch.data_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;

		dir_rows = '{
			typed_err(mk_body(8'hA5), ST_STRAY),
			mk_start(0, 0, 0, 1, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000),
			typed_err(mk_body(8'h3C), ST_STRAY),
			mk_start(1, 3, 1, 0, 16'hA5A5, 16'hFFFF, 16'd2, 16'd1),
			mk_body(8'h00),
			mk_body(8'hFF),
			mk_body(8'h5A),
			typed_err(mk_body(8'hC3), ST_STRAY),
			mk_start(0, 1, 0, 2, 16'h4142, 16'h1234, 16'hFFFF, 16'd2),
			mk_body(8'h11),
			mk_start(1, 2, 0, 1, 16'h0001, 16'h8000, 16'd0, 16'd248),
			mk_body(8'h80),
			mk_start(0, 0, 1, 1, 16'h7FFF, 16'h00FF, 16'd0, 16'd249),
			mk_start(0, 3, 0, 2, 16'h5A5A, 16'hA5A5, 16'h1111, 16'd503),
			typed_err(mk_start(1, 0, 0, 1, 16'h0000, 16'h0000, 16'd0, 16'd504), ST_SHORT),
			typed_err(mk_body(8'h01), ST_STRAY),
			mk_start(1, 3, 1, 3, 16'hBEEF, 16'hCAFE, 16'hFFFF, 16'd1),
			mk_body(8'h01),
			typed_err(mk_start(0, 3, 0, 0, 16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF),
				ST_SHORT),
			mk_start(0, 2, 1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0),
			mk_start(0, 3, 0, 0, 16'h0000, 16'h0000, 16'd0, 16'd0)
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_req(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].st);

		set_limit(16'hFFFF);
		run_phase(22);
		set_limit(16'h0000);
		run_phase(8);
		idling = 1'b0;
		set_limit(16'd258);
		run_phase(22);
		idling = 1'b1;
		set_limit(16'($urandom_range(7, 600)));
		run_phase(22);
		idling = 1'b0;
		set_limit(LIMIT_RESET);
		run_phase(18);

		req_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
